>>> src/eosd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eosd_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int DIST_WIDTH = 31;
   localparam int FRAC_BITS  = 16;

   localparam logic [DIST_WIDTH-1:0] SPACING_RESET = 31'd65536;

   // quotient bits of every divider, one per pipeline stage
   localparam int DIV_QUO_WIDTH = 51;
   // |dv| * 2^16, |dv| < 2^32
   localparam int FT_NUM_WIDTH  = 48;
   // |m| * d * 2^15, |m| * d < 2^64
   localparam int CV_NUM_WIDTH  = 79;
   // h * h
   localparam int CV_DEN_WIDTH  = 62;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] far_left;
      logic signed [WORD_WIDTH-1:0] near_left;
      logic signed [WORD_WIDTH-1:0] center;
      logic signed [WORD_WIDTH-1:0] near_right;
      logic signed [WORD_WIDTH-1:0] far_right;
      logic [DIST_WIDTH-1:0]        right_distance;
      logic [DIST_WIDTH-1:0]        left_distance;
   } eosd_req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] right_slope;
      logic signed [WORD_WIDTH-1:0] left_slope;
   } eosd_rsp_type;

   // flags that travel alongside the dividers
   typedef struct packed {
      logic neg_dv_r;
      logic neg_dv_l;
      logic neg_m_r;
      logic neg_m_l;
      logic cap_r;
      logic cap_l;
   } eosd_side_type;

endpackage

`default_nettype wire

>>> src/eosd_div.sv
`timescale 1ns / 1ps
`default_nettype none

// pipelined restoring divider, one quotient bit per stage, QUO_WIDTH >= 2
module eosd_div #(
   parameter int NUM_WIDTH = eosd_pkg::FT_NUM_WIDTH,
   parameter int DEN_WIDTH = eosd_pkg::DIST_WIDTH,
   parameter int QUO_WIDTH = eosd_pkg::DIV_QUO_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic [NUM_WIDTH-1:0] num_in,
   input  wire logic [DEN_WIDTH-1:0] den_in,
   output logic      [QUO_WIDTH-1:0] quo_out
);

   localparam int CMP_WIDTH = NUM_WIDTH + DEN_WIDTH + QUO_WIDTH;

   logic [NUM_WIDTH-1:0] rem_ff [QUO_WIDTH-1];
   logic [DEN_WIDTH-1:0] den_ff [QUO_WIDTH-1];
   logic [QUO_WIDTH-1:0] quo_ff [QUO_WIDTH];

   for (genvar i = 0; i < QUO_WIDTH; i++) begin : g_stage
      logic [NUM_WIDTH-1:0] rem_prev;
      logic [DEN_WIDTH-1:0] den_prev;
      logic [QUO_WIDTH-1:0] quo_prev;
      logic [CMP_WIDTH:0]   trial;
      logic [NUM_WIDTH-1:0] rem_in;
      logic [QUO_WIDTH-1:0] quo_in;

      if (i == 0) begin : g_first
         assign rem_prev = num_in;
         assign den_prev = den_in;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      assign trial  = {{(DEN_WIDTH+QUO_WIDTH+1){1'b0}}, rem_prev}
                    - ({{(NUM_WIDTH+QUO_WIDTH+1){1'b0}}, den_prev} << (QUO_WIDTH-1-i));
      assign rem_in = trial[CMP_WIDTH] ? rem_prev : trial[NUM_WIDTH-1:0];
      assign quo_in = {quo_prev[QUO_WIDTH-2:0], ~trial[CMP_WIDTH]};

      always_ff @(posedge clock) begin
         quo_ff[i] <= quo_in;
      end

      if (i < QUO_WIDTH-1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_prev;
         end
      end
   end

   assign quo_out = quo_ff[QUO_WIDTH-1];

endmodule

`default_nettype wire

>>> src/eno_one_sided_derivatives_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// a request passes stages 1, 2 and 3, the divider pipelines, stage 5 and the stage 6
// output register; throughput: one request per cycle, busy never rises; the
// divider pipelines have 51 stages, one quotient bit per stage
// the receiver cannot stall, so results leave on rsp_valid without back-pressure
// reset (synchronous, active high) empties the pipeline and sets spacing to 1.0
module eno_one_sided_derivatives_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire eosd_pkg::eosd_req_type            req_data,
   output logic                                   rsp_valid,
   output eosd_pkg::eosd_rsp_type                 rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [eosd_pkg::DIST_WIDTH-1:0]   csr_data
);

   import eosd_pkg::*;

   localparam int QW = DIV_QUO_WIDTH;

   // minmod: zero on opposite signs, smaller magnitude otherwise, tie takes y
   function automatic logic signed [34:0] minmod(input logic signed [34:0] x,
                                                 input logic signed [34:0] y);
      logic [34:0] ax;
      logic [34:0] ay;
      ax = x[34] ? -x : x;
      ay = y[34] ? -y : y;
      if ((x[34] && y > 0) || (x > 0 && y[34])) begin
         return '0;
      end else if (ax < ay) begin
         return x;
      end else begin
         return y;
      end
   endfunction

   // grid spacing, held already forced to at least one lsb
   logic [DIST_WIDTH-1:0] spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_RESET;
      end else if (csr_valid && csr_ready) begin
         spacing_ff <= (csr_data == '0) ? DIST_WIDTH'(1) : csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // ---------------- stage 1: second differences and first differences
   logic                  accept;
   logic [DIST_WIDTH-1:0] dr_in, dl_in;
   logic signed [34:0]    c_in, cr_in, cl_in;
   logic signed [32:0]    dvr_in, dvl_in;
   logic signed [31:0]    vr, vl;

   assign accept = start && !busy;
   assign dr_in  = (req_data.right_distance == '0) ? DIST_WIDTH'(1) : req_data.right_distance;
   assign dl_in  = (req_data.left_distance == '0) ? DIST_WIDTH'(1) : req_data.left_distance;
   assign c_in   = 35'(req_data.near_left) + 35'(req_data.near_right)
                 - (35'(req_data.center) <<< 1);
   assign cr_in  = 35'(req_data.center) + 35'(req_data.far_right)
                 - (35'(req_data.near_right) <<< 1);
   assign cl_in  = 35'(req_data.center) + 35'(req_data.far_left)
                 - (35'(req_data.near_left) <<< 1);
   // where a distance differs from the spacing the neighbour counts as zero
   assign vr     = (dr_in == spacing_ff) ? req_data.near_right : '0;
   assign vl     = (dl_in == spacing_ff) ? req_data.near_left : '0;
   assign dvr_in = 33'(vr) - 33'(req_data.center);
   assign dvl_in = 33'(req_data.center) - 33'(vl);

   logic                  s1_valid_ff;
   logic [DIST_WIDTH-1:0] s1_dr_ff, s1_dl_ff;
   logic signed [34:0]    s1_c_ff, s1_cr_ff, s1_cl_ff;
   logic signed [32:0]    s1_dvr_ff, s1_dvl_ff;

   always_ff @(posedge clock) begin
      s1_dr_ff  <= dr_in;
      s1_dl_ff  <= dl_in;
      s1_c_ff   <= c_in;
      s1_cr_ff  <= cr_in;
      s1_cl_ff  <= cl_in;
      s1_dvr_ff <= dvr_in;
      s1_dvl_ff <= dvl_in;
   end

   // ---------------- stage 2: minmod, magnitudes, h squared
   logic signed [34:0] mr, ml;
   logic [34:0]        amr, aml;
   logic [32:0]        advr, advl;
   logic [61:0]        hh_in;

   assign mr    = minmod(s1_c_ff, s1_cr_ff);
   assign ml    = minmod(s1_c_ff, s1_cl_ff);
   assign amr   = mr[34] ? -mr : mr;
   assign aml   = ml[34] ? -ml : ml;
   assign advr  = s1_dvr_ff[32] ? -s1_dvr_ff : s1_dvr_ff;
   assign advl  = s1_dvl_ff[32] ? -s1_dvl_ff : s1_dvl_ff;
   assign hh_in = 62'(spacing_ff) * 62'(spacing_ff);

   logic                  s2_valid_ff;
   logic [DIST_WIDTH-1:0] s2_dr_ff, s2_dl_ff;
   logic [33:0]           s2_amr_ff, s2_aml_ff;
   logic [31:0]           s2_advr_ff, s2_advl_ff;
   logic [61:0]           s2_hh_ff;
   eosd_side_type         s2_side_ff;

   always_ff @(posedge clock) begin
      s2_dr_ff            <= s1_dr_ff;
      s2_dl_ff            <= s1_dl_ff;
      s2_amr_ff           <= amr[33:0];
      s2_aml_ff           <= aml[33:0];
      s2_advr_ff          <= advr[31:0];
      s2_advl_ff          <= advl[31:0];
      s2_hh_ff            <= hh_in;
      s2_side_ff.neg_dv_r <= s1_dvr_ff[32];
      s2_side_ff.neg_dv_l <= s1_dvl_ff[32];
      s2_side_ff.neg_m_r  <= mr[34];
      s2_side_ff.neg_m_l  <= ml[34];
      s2_side_ff.cap_r    <= 1'b0;
      s2_side_ff.cap_l    <= 1'b0;
   end

   // ---------------- stage 3: |m| * d, one multiplier per side
   logic                  s3_valid_ff;
   logic [DIST_WIDTH-1:0] s3_dr_ff, s3_dl_ff;
   logic [63:0]           s3_xr_ff, s3_xl_ff;
   logic [31:0]           s3_advr_ff, s3_advl_ff;
   logic [61:0]           s3_hh_ff;
   eosd_side_type         s3_side_ff;

   always_ff @(posedge clock) begin
      s3_dr_ff   <= s2_dr_ff;
      s3_dl_ff   <= s2_dl_ff;
      s3_xr_ff   <= 64'(s2_amr_ff * s2_dr_ff);
      s3_xl_ff   <= 64'(s2_aml_ff * s2_dl_ff);
      s3_advr_ff <= s2_advr_ff;
      s3_advl_ff <= s2_advl_ff;
      s3_hh_ff   <= s2_hh_ff;
      s3_side_ff <= s2_side_ff;
   end

   // ---------------- dividers: |dv| 2^16 / d and |m| d 2^15 / h^2
   // the cap flag marks a first quotient x / h of 2^36 or more
   eosd_side_type side_in;

   always_comb begin
      side_in       = s3_side_ff;
      side_in.cap_r = {3'b0, s3_xr_ff} >= {spacing_ff, 36'b0};
      side_in.cap_l = {3'b0, s3_xl_ff} >= {spacing_ff, 36'b0};
   end

   logic [QW-1:0] q1r, q1l, q2r, q2l;

   eosd_div #(.NUM_WIDTH(FT_NUM_WIDTH), .DEN_WIDTH(DIST_WIDTH), .QUO_WIDTH(QW)) u_div_ftr (
      .clock   (clock),
      .num_in  ({s3_advr_ff, 16'b0}),
      .den_in  (s3_dr_ff),
      .quo_out (q1r)
   );

   eosd_div #(.NUM_WIDTH(FT_NUM_WIDTH), .DEN_WIDTH(DIST_WIDTH), .QUO_WIDTH(QW)) u_div_ftl (
      .clock   (clock),
      .num_in  ({s3_advl_ff, 16'b0}),
      .den_in  (s3_dl_ff),
      .quo_out (q1l)
   );

   eosd_div #(.NUM_WIDTH(CV_NUM_WIDTH), .DEN_WIDTH(CV_DEN_WIDTH), .QUO_WIDTH(QW)) u_div_cvr (
      .clock   (clock),
      .num_in  ({s3_xr_ff, 15'b0}),
      .den_in  (s3_hh_ff),
      .quo_out (q2r)
   );

   eosd_div #(.NUM_WIDTH(CV_NUM_WIDTH), .DEN_WIDTH(CV_DEN_WIDTH), .QUO_WIDTH(QW)) u_div_cvl (
      .clock   (clock),
      .num_in  ({s3_xl_ff, 15'b0}),
      .den_in  (s3_hh_ff),
      .quo_out (q2l)
   );

   // flags and valid ride in step with the divider stages
   logic [QW-1:0] div_valid_ff;
   eosd_side_type side_ff [QW];

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < QW; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // ---------------- stage 5: signs, cap and the final add
   localparam logic [QW-1:0] TERM_CAP = QW'(1) << 50;

   eosd_side_type      side_out;
   logic [QW-1:0]      c2r, c2l;
   logic signed [52:0] t1r, t1l, t2r, t2l;

   assign side_out = side_ff[QW-1];
   assign c2r = (side_out.cap_r || q2r > TERM_CAP) ? TERM_CAP : q2r;
   assign c2l = (side_out.cap_l || q2l > TERM_CAP) ? TERM_CAP : q2l;
   assign t1r = side_out.neg_dv_r ? -53'(q1r) : 53'(q1r);
   assign t1l = side_out.neg_dv_l ? -53'(q1l) : 53'(q1l);
   assign t2r = side_out.neg_m_r ? -53'(c2r) : 53'(c2r);
   assign t2l = side_out.neg_m_l ? -53'(c2l) : 53'(c2l);

   logic               s5_valid_ff;
   logic signed [52:0] s5_sr_ff, s5_sl_ff;

   always_ff @(posedge clock) begin
      s5_sr_ff <= t1r - t2r;
      s5_sl_ff <= t1l + t2l;
   end

   // ---------------- stage 6: saturate into the output register
   localparam logic signed [52:0] SAT_MAX = 53'((64'sd1 <<< (WORD_WIDTH-1)) - 64'sd1);
   localparam logic signed [52:0] SAT_MIN = -SAT_MAX - 53'sd1;

   function automatic logic signed [WORD_WIDTH-1:0] saturate(input logic signed [52:0] v);
      if (v > SAT_MAX) begin
         return SAT_MAX[WORD_WIDTH-1:0];
      end else if (v < SAT_MIN) begin
         return SAT_MIN[WORD_WIDTH-1:0];
      end else begin
         return v[WORD_WIDTH-1:0];
      end
   endfunction

   logic         rsp_valid_ff;
   eosd_rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      rsp_data_ff.right_slope <= saturate(s5_sr_ff);
      rsp_data_ff.left_slope  <= saturate(s5_sl_ff);
   end

   // valid chain, the only state that reset clears besides spacing
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         div_valid_ff <= '0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         div_valid_ff <= {div_valid_ff[QW-2:0], s3_valid_ff};
         s5_valid_ff  <= div_valid_ff[QW-1];
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
